/* rtl/afm_pkg.sv */
// Shared constants, types and codes of the autofocus area coordinate mapper.
package afm_pkg;

   localparam int CFG_W         = 13;
   localparam int COORD_W       = 11;
   localparam int PIX_W         = 16;
   localparam int SLOT_W        = 3;
   localparam int CNT_W         = 3;
   localparam int RATIO_W       = 16;
   localparam int HALF_W        = 12;
   localparam int SC_W          = 18;
   localparam int DIV_W         = 31;
   localparam int MUL_W         = DIV_W;
   localparam int DVSR_W        = 14;
   localparam int RECIP_W       = 13;
   localparam int RECIP_SH      = 16;
   localparam int Q1000_SH      = 39;
   localparam int CSR_ADDR_W    = 2;
   localparam int MAX_AREAS_DEF = 5;

   localparam logic [CFG_W-1:0]   OUT_W_RST  = 13'd2048;
   localparam logic [CFG_W-1:0]   OUT_H_RST  = 13'd1536;
   localparam logic [CFG_W-1:0]   PRV_W_RST  = 13'd2048;
   localparam logic [CFG_W-1:0]   PRV_H_RST  = 13'd1536;
   localparam logic [CFG_W-1:0]   HEIGHT_ODD = 13'd1088;
   localparam logic [CFG_W-1:0]   HEIGHT_STD = 13'd1080;
   localparam logic [RATIO_W-1:0] SCALE      = 16'd1000;
   localparam logic [RECIP_W-1:0] RECIP9     = 13'd7282;
   localparam logic [MUL_W-2:0]   RECIP1000  = 30'd549755814;
   localparam logic [1:0]         LAST_CORNER = 2'd3;

   localparam logic CMD_ADD    = 1'b0;
   localparam logic CMD_COMMIT = 1'b1;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_OUT_WIDTH  = 2'd0,
      CSR_OUT_HEIGHT = 2'd1,
      CSR_PRV_WIDTH  = 2'd2,
      CSR_PRV_HEIGHT = 2'd3
   } csr_idx_type;

   typedef enum logic [2:0] {
      PH_RATIO = 3'b001,
      PH_SCALE = 3'b010,
      PH_PIXEL = 3'b100
   } phase_type;

   typedef logic [3:0][COORD_W-1:0] corners_type;
   typedef logic [3:0][PIX_W-1:0]   pixels_type;

   typedef struct packed {
      logic start;
      logic ack;
   } core_ctl_type;

   typedef struct packed {
      logic                    start;
      logic signed [DIV_W-1:0] dividend;
      logic [DVSR_W-1:0]       divisor;
   } div_req_type;

   typedef struct packed {
      logic                    done;
      logic signed [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage

/* rtl/af_area_coordinate_mapper.sv */
// Top level of the autofocus area coordinate mapper: channels, registers and area bookkeeping.
//
// Input channel req_*: one transfer per command. req_tuser is the command (add one area or
// commit); req_tdata carries the four normalized edges. Result channel rsp_*: one transfer per
// command, with the slot and mapped edges of an added area, the drop flag, or (rsp_tuser high)
// the active area count of a commit.
// Configuration: csr_we writes csr_wdata to register csr_addr (output width, output height,
// preview width, preview height) in the same clock edge; write only while no command is open.
// Sequence: a commit or a dropped area needs no work in the core; its result is loaded into
// the output register once that register is free. Each edge of a mapped area takes a product
// and a multiply by the reciprocal of 1000 on the shared multiplier, then a sign step, twice.
// A ratio correction adds a product and a division in the shared radix-2 divider. One command
// is worked at a time; req_tready is low from the accepted transfer until its result enters
// the output register.
// Reset (synchronous, active high) restores the default resolutions and empties all slots.
// A stalled receiver holds the result in the output register; the next command is still
// accepted and worked, and its result waits until the output register is free.
module af_area_coordinate_mapper
   import afm_pkg::*;
#(
   parameter int MAX_AREAS = MAX_AREAS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [47:0]           req_tdata,   // left, top, right, bottom, zero pad
   input  logic                  req_tuser,   // command
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [71:0]           rsp_tdata,   // area_slot, left_out, top_out, right_out,
                                              // bottom_out, active_areas, dropped, zero pad
   output logic                  rsp_tuser,   // is_commit
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CFG_W-1:0]      csr_wdata
);

   logic [CFG_W-1:0]  out_width_ff, out_height_ff, prv_width_ff, prv_height_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              first_zero_ff, first_zero_in;
   logic              busy_ff, busy_in;
   logic              add_ff, add_in;
   logic              commit_ff, commit_in;
   logic              dropped_ff, dropped_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [CNT_W-1:0]  active_ff, active_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [71:0]       rsp_data_ff, rsp_data_in;
   logic              rsp_user_ff, rsp_user_in;

   logic              accept;
   logic              out_free;
   logic              result_ready;
   logic              load;
   logic              full;
   logic              all_zero;
   corners_type       corners;
   core_ctl_type      core_ctl;
   logic              core_done;
   pixels_type        core_res;
   pixels_type        edges;

   afm_core u_core (
      .clock          (clock),
      .reset          (reset),
      .ctl            (core_ctl),
      .corners        (corners),
      .out_width      (out_width_ff),
      .out_height     (out_height_ff),
      .preview_width  (prv_width_ff),
      .preview_height (prv_height_ff),
      .done           (core_done),
      .res            (core_res)
   );

   always_comb begin
      corners[0] = req_tdata[COORD_W-1:0];
      corners[1] = req_tdata[2*COORD_W-1:COORD_W];
      corners[2] = req_tdata[3*COORD_W-1:2*COORD_W];
      corners[3] = req_tdata[4*COORD_W-1:3*COORD_W];
      all_zero   = (req_tdata[4*COORD_W-1:0] == '0);

      accept       = req_tvalid && req_tready;
      out_free     = !rsp_valid_ff || rsp_tready;
      full         = (count_ff >= CNT_W'(MAX_AREAS));
      result_ready = busy_ff && (!add_ff || core_done);
      load         = result_ready && out_free;

      core_ctl.start = accept && (req_tuser == CMD_ADD) && !full;
      core_ctl.ack   = load && add_ff;

      count_in      = count_ff;
      first_zero_in = first_zero_ff;
      busy_in       = busy_ff;
      add_in        = add_ff;
      commit_in     = commit_ff;
      dropped_in    = dropped_ff;
      slot_in       = slot_ff;
      active_in     = active_ff;

      if (load) begin
         busy_in = 1'b0;
      end

      if (accept) begin
         busy_in    = 1'b1;
         add_in     = 1'b0;
         commit_in  = 1'b0;
         dropped_in = 1'b0;
         slot_in    = '0;
         active_in  = '0;
         if (req_tuser == CMD_COMMIT) begin
            commit_in     = 1'b1;
            active_in     = ((count_ff == CNT_W'(1)) && first_zero_ff) ? '0 : count_ff;
            count_in      = '0;
            first_zero_in = 1'b0;
         end else if (full) begin
            dropped_in = 1'b1;
         end else begin
            add_in   = 1'b1;
            slot_in  = count_ff;
            count_in = count_ff + 1'b1;
            if (count_ff == '0) begin
               first_zero_in = all_zero;
            end
         end
      end

      edges = add_ff ? core_res : '0;

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_user_in  = commit_ff;
         rsp_data_in  = {1'b0, dropped_ff, active_ff, edges[3], edges[2], edges[1], edges[0],
                         slot_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_width_ff  <= OUT_W_RST;
         out_height_ff <= OUT_H_RST;
         prv_width_ff  <= PRV_W_RST;
         prv_height_ff <= PRV_H_RST;
         count_ff      <= '0;
         first_zero_ff <= 1'b0;
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_idx_type'(csr_addr))
               CSR_OUT_WIDTH:  out_width_ff  <= csr_wdata;
               CSR_OUT_HEIGHT: out_height_ff <= csr_wdata;
               CSR_PRV_WIDTH:  prv_width_ff  <= csr_wdata;
               CSR_PRV_HEIGHT: prv_height_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         count_ff      <= count_in;
         first_zero_ff <= first_zero_in;
         busy_ff       <= busy_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      add_ff      <= add_in;
      commit_ff   <= commit_in;
      dropped_ff  <= dropped_in;
      slot_ff     <= slot_in;
      active_ff   <= active_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign req_tready = !busy_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

/* rtl/afm_div.sv */
// Radix-2 restoring divider, signed dividend, truncating quotient.
module afm_div
   import afm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   localparam int MAG_W = DIV_W - 1;
   localparam int ITER_W = $clog2(MAG_W);

   typedef enum logic [2:0] {
      DV_IDLE = 3'b001,
      DV_RUN  = 3'b010,
      DV_DONE = 3'b100
   } dv_state_type;

   dv_state_type      state_ff, state_in;
   logic [DVSR_W-1:0] rem_ff, rem_in;
   logic [MAG_W-1:0]  quo_ff, quo_in;
   logic [DVSR_W-1:0] dvsr_ff, dvsr_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic              neg_ff, neg_in;

   logic [DVSR_W:0]   trial;
   logic [DVSR_W:0]   diff;
   logic              fits;
   logic [DIV_W-1:0]  mag_full;

   always_comb begin
      trial    = {rem_ff, quo_ff[MAG_W-1]};
      diff     = trial - {1'b0, dvsr_ff};
      fits     = trial >= {1'b0, dvsr_ff};
      mag_full = req.dividend[DIV_W-1] ? -req.dividend : req.dividend;

      state_in = state_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvsr_in  = dvsr_ff;
      iter_in  = iter_ff;
      neg_in   = neg_ff;

      case (state_ff)
         DV_IDLE: begin
            if (req.start) begin
               neg_in   = req.dividend[DIV_W-1];
               quo_in   = mag_full[MAG_W-1:0];
               rem_in   = '0;
               dvsr_in  = req.divisor;
               iter_in  = '0;
               state_in = DV_RUN;
            end
         end
         DV_RUN: begin
            rem_in  = fits ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
            quo_in  = {quo_ff[MAG_W-2:0], fits};
            iter_in = iter_ff + 1'b1;
            if (iter_ff == ITER_W'(MAG_W - 1)) begin
               state_in = DV_DONE;
            end
         end
         DV_DONE: begin
            state_in = DV_IDLE;
         end
         default: begin
            state_in = DV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
      end else begin
         state_ff <= state_in;
      end
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvsr_ff <= dvsr_in;
      iter_ff <= iter_in;
      neg_ff  <= neg_in;
   end

   assign rsp.done     = (state_ff == DV_DONE);
   assign rsp.quotient = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});

endmodule

/* rtl/afm_core.sv */
// Sequencer with shared multiplier and divider that maps the four corners of one area.
module afm_core
   import afm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  core_ctl_type     ctl,
   input  corners_type      corners,
   input  logic [CFG_W-1:0] out_width,
   input  logic [CFG_W-1:0] out_height,
   input  logic [CFG_W-1:0] preview_width,
   input  logic [CFG_W-1:0] preview_height,
   output logic             done,
   output pixels_type       res
);

   typedef enum logic [7:0] {
      ST_IDLE = 8'b00000001,
      ST_PREP = 8'b00000010,
      ST_MUL  = 8'b00000100,
      ST_REC  = 8'b00001000,
      ST_SGN  = 8'b00010000,
      ST_DST  = 8'b00100000,
      ST_DWT  = 8'b01000000,
      ST_DONE = 8'b10000000
   } state_type;

   state_type               state_ff, state_in;
   phase_type               phase_ff, phase_in;
   corners_type             corners_ff, corners_in;
   logic [RATIO_W-1:0]      xr_ff, xr_in;
   logic [RATIO_W-1:0]      yr_ff, yr_in;
   logic [1:0]              idx_ff, idx_in;
   logic signed [DIV_W-1:0] prod_ff, prod_in;
   logic signed [SC_W-1:0]  scaled_ff, scaled_in;
   logic [SC_W-1:0]         rq_ff, rq_in;
   pixels_type              res_ff, res_in;
   logic [CFG_W-1:0]        base_ff, base_in;
   logic [DVSR_W-1:0]       dvsr_ff, dvsr_in;
   logic                    tgt_y_ff, tgt_y_in;

   logic [CFG_W-1:0]            yo_adj;
   logic [CFG_W-1:0]            ph_adj;
   logic [CFG_W-1:0]            xo_34;
   logic [CFG_W-1:0]            pw_34;
   logic [CFG_W-1:0]            pw_916;
   logic [CFG_W+RECIP_W-1:0]    ph_recip;
   logic [DVSR_W-1:0]           d_a;
   logic [DVSR_W-1:0]           d_c;
   logic                        cond_a;
   logic                        cond_b;
   logic                        cond_c;
   logic [HALF_W-1:0]           half;
   logic [COORD_W-1:0]          coord;
   logic signed [SC_W-1:0]      pix_base;
   logic [DIV_W-1:0]            prod_mag;
   logic signed [SC_W-1:0]      sval;
   logic signed [MUL_W-1:0]     mul_a;
   logic [MUL_W-2:0]            mul_b;
   logic signed [2*MUL_W-1:0]   mul_p;
   div_req_type                 div_req;
   div_rsp_type                 div_rsp;

   afm_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_comb begin
      yo_adj   = (out_height == HEIGHT_ODD) ? HEIGHT_STD : out_height;
      ph_adj   = (preview_height == HEIGHT_ODD) ? HEIGHT_STD : preview_height;
      xo_34    = {2'b00, out_width[CFG_W-1:2]} + {1'b0, out_width[CFG_W-1:2], 1'b0};
      pw_34    = {2'b00, preview_width[CFG_W-1:2]} + {1'b0, preview_width[CFG_W-1:2], 1'b0};
      pw_916   = {4'b0000, preview_width[CFG_W-1:4]} + {1'b0, preview_width[CFG_W-1:4], 3'b000};
      ph_recip = ph_adj * RECIP9;
      d_a      = {1'b0, pw_34};
      d_c      = {ph_recip[RECIP_SH+DVSR_W-5:RECIP_SH], 4'b0000};
      cond_a   = (xo_34 == yo_adj);
      cond_b   = (pw_916 == ph_adj);
      cond_c   = (pw_34 == ph_adj);
      half     = idx_ff[0] ? yo_adj[CFG_W-1:1] : out_width[CFG_W-1:1];
      coord    = corners_ff[idx_ff];
      pix_base = scaled_ff + $signed({{(SC_W-RATIO_W){1'b0}}, SCALE});
      prod_mag = prod_ff[DIV_W-1] ? -prod_ff : prod_ff;
      sval     = prod_ff[DIV_W-1] ? -$signed(rq_ff) : $signed(rq_ff);

      if (state_ff == ST_REC) begin
         mul_a = $signed(prod_mag);
         mul_b = RECIP1000;
      end else begin
         case (phase_ff)
            PH_RATIO: begin
               mul_a = $signed({{(MUL_W-CFG_W){1'b0}}, base_ff});
               mul_b = {{(MUL_W-1-RATIO_W){1'b0}}, SCALE};
            end
            PH_SCALE: begin
               mul_a = $signed({{(MUL_W-COORD_W){coord[COORD_W-1]}}, coord});
               mul_b = {{(MUL_W-1-RATIO_W){1'b0}}, (idx_ff[0] ? yr_ff : xr_ff)};
            end
            PH_PIXEL: begin
               mul_a = $signed({{(MUL_W-SC_W){pix_base[SC_W-1]}}, pix_base});
               mul_b = {{(MUL_W-1-HALF_W){1'b0}}, half};
            end
            default: begin
               mul_a = '0;
               mul_b = '0;
            end
         endcase
      end
      mul_p = mul_a * $signed({1'b0, mul_b});

      div_req.start    = (state_ff == ST_DST);
      div_req.dividend = prod_ff;
      div_req.divisor  = dvsr_ff;

      state_in   = state_ff;
      phase_in   = phase_ff;
      corners_in = corners_ff;
      xr_in      = xr_ff;
      yr_in      = yr_ff;
      idx_in     = idx_ff;
      prod_in    = prod_ff;
      scaled_in  = scaled_ff;
      rq_in      = rq_ff;
      res_in     = res_ff;
      base_in    = base_ff;
      dvsr_in    = dvsr_ff;
      tgt_y_in   = tgt_y_ff;

      case (state_ff)
         ST_IDLE: begin
            if (ctl.start) begin
               corners_in = corners;
               state_in   = ST_PREP;
            end
         end
         ST_PREP: begin
            xr_in    = SCALE;
            yr_in    = SCALE;
            idx_in   = '0;
            state_in = ST_MUL;
            phase_in = PH_SCALE;
            if (cond_a) begin
               if (cond_b && (d_a != '0)) begin
                  phase_in = PH_RATIO;
                  base_in  = ph_adj;
                  dvsr_in  = d_a;
                  tgt_y_in = 1'b1;
               end
            end else if (cond_c && (d_c != '0)) begin
               phase_in = PH_RATIO;
               base_in  = preview_width;
               dvsr_in  = d_c;
               tgt_y_in = 1'b0;
            end
         end
         ST_MUL: begin
            prod_in = mul_p[DIV_W-1:0];
            if (phase_ff == PH_RATIO) begin
               state_in = ST_DST;
            end else begin
               state_in = ST_REC;
            end
         end
         ST_REC: begin
            rq_in    = mul_p[Q1000_SH+SC_W-1:Q1000_SH];
            state_in = ST_SGN;
         end
         ST_SGN: begin
            state_in = ST_MUL;
            case (phase_ff)
               PH_SCALE: begin
                  scaled_in = sval;
                  phase_in  = PH_PIXEL;
               end
               PH_PIXEL: begin
                  res_in[idx_ff] = sval[PIX_W-1:0];
                  phase_in       = PH_SCALE;
                  if (idx_ff == LAST_CORNER) begin
                     state_in = ST_DONE;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
               default: begin
                  phase_in = PH_SCALE;
               end
            endcase
         end
         ST_DST: begin
            state_in = ST_DWT;
         end
         ST_DWT: begin
            if (div_rsp.done) begin
               state_in = ST_MUL;
               phase_in = PH_SCALE;
               if (tgt_y_ff) begin
                  yr_in = div_rsp.quotient[RATIO_W-1:0];
               end else begin
                  xr_in = div_rsp.quotient[RATIO_W-1:0];
               end
            end
         end
         ST_DONE: begin
            if (ctl.ack) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_SCALE;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
      corners_ff <= corners_in;
      xr_ff      <= xr_in;
      yr_ff      <= yr_in;
      idx_ff     <= idx_in;
      prod_ff    <= prod_in;
      scaled_ff  <= scaled_in;
      rq_ff      <= rq_in;
      res_ff     <= res_in;
      base_ff    <= base_in;
      dvsr_ff    <= dvsr_in;
      tgt_y_ff   <= tgt_y_in;
   end

   assign done = (state_ff == ST_DONE);
   assign res  = res_ff;

endmodule
